// ----- sv/cxbs_pkg.sv -----
// ----------------------------------------------------------------------------
// cxbs_pkg
// Types, sizes and helpers for the chained XOR byte scrambler.
// ----------------------------------------------------------------------------
package cxbs_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int MAX_CHUNK = 65536;

  localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_LW   = $clog2(KEY_DEPTH + 1);
  localparam int CHUNK_PW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
  localparam int CHUNK_LW = $clog2(MAX_CHUNK + 1);

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  localparam logic [8:0]  KEY_LENGTH_RESET   = 9'd256;
  localparam logic [16:0] CHUNK_LENGTH_RESET = 17'd256;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_KEY     = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_KEY_MODE     = 2'd0,
    CFG_DIRECTION    = 2'd1,
    CFG_KEY_LENGTH   = 2'd2,
    CFG_CHUNK_LENGTH = 2'd3
  } cfg_index_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
    logic [7:0] key_index;
    logic       last_in;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } result_t;

  function automatic logic [KEY_LW-1:0] clamp_key_length(logic [8:0] v);
    if (v == 9'd0) return KEY_LW'(1);
    if (32'(v) > KEY_DEPTH) return KEY_LW'(KEY_DEPTH);
    return KEY_LW'(v);
  endfunction

  function automatic logic [CHUNK_LW-1:0] clamp_chunk_length(logic [16:0] v);
    if (v == 17'd0) return CHUNK_LW'(1);
    if (32'(v) > MAX_CHUNK) return CHUNK_LW'(MAX_CHUNK);
    return CHUNK_LW'(v);
  endfunction

endpackage

// ----- sv/chained_xor_byte_scrambler.sv -----
// ----------------------------------------------------------------------------
// chained_xor_byte_scrambler
// Byte scrambler with ciphertext feedback and stored or LCG-generated keys.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall / item) carries commands: process
//   a data byte, write a key byte into the key store, or restart the stream.
//   Only data bytes produce a transaction on the result channel
//   (result_valid / result_stall / result), in order, with last_in copied.
//   The cfg channel (cfg_valid / cfg_ready, always ready) writes key_mode,
//   direction, key_length and chunk_length; write it only while idle.
// Timing:
//   One item per cycle sustained while the result channel is not stalled. A data
//   byte passes the synchronous key store read into the read stage registers,
//   then the LCG step and XOR into the output register.
// Reset:
//   Synchronous rst clears positions, LCG seed, feedback byte and registers
//   to their defaults. The key store is not cleared; write keys before use.
// Stall:
//   A stalled result holds; the read stage keeps accepting into an empty
//   slot, and item_stall rises only when both stages hold transactions.
// ----------------------------------------------------------------------------
module chained_xor_byte_scrambler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  cxbs_pkg::item_t         item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output cxbs_pkg::result_t       result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  cxbs_pkg::cfg_index_t    cfg_index,
  input  logic [16:0]             cfg_data
);
  import cxbs_pkg::*;

  logic [7:0]          key_store [KEY_DEPTH];
  logic [7:0]          key_rdata;

  logic                key_mode;
  logic                direction;
  logic [KEY_LW-1:0]   key_len;
  logic [CHUNK_LW-1:0] chunk_len;

  logic [KEY_AW-1:0]   key_pos;
  logic [CHUNK_PW-1:0] chunk_pos;

  logic                s1_valid;
  cmd_t                s1_cmd;
  logic                s1_reseed;
  logic [7:0]          s1_data;
  logic                s1_last;

  logic [31:0]         lcg_seed;
  logic [7:0]          feedback_byte;

  logic                accept;
  logic                out_open;
  logic                s1_fire;
  logic                is_data;
  logic                is_key;
  logic                is_restart;
  logic                key_wr_ok;
  logic                reseed;
  logic                use_store;
  logic [KEY_AW:0]     key_pos_inc;
  logic [CHUNK_PW:0]   chunk_pos_inc;
  logic [KEY_AW-1:0]   key_pos_next;
  logic [CHUNK_PW-1:0] chunk_pos_next;
  logic [31:0]         seed_base;
  logic [31:0]         seed_next;
  logic [7:0]          key_byte;
  logic [7:0]          cipher;

  assign cfg_ready  = 1'b1;
  assign out_open   = !result_valid || !result_stall;
  assign item_stall = s1_valid && !out_open;
  assign accept     = item_valid && !item_stall;
  assign s1_fire    = s1_valid && out_open;

  assign is_data    = (item.command == CMD_DATA);
  assign is_key     = (item.command == CMD_KEY);
  assign is_restart = (item.command == CMD_RESTART);
  assign key_wr_ok  = (32'(item.key_index) < KEY_DEPTH);

  assign reseed    = key_mode && (chunk_pos == '0);
  assign use_store = !key_mode || reseed;

  assign key_pos_inc    = {1'b0, key_pos} + 1'b1;
  assign chunk_pos_inc  = {1'b0, chunk_pos} + 1'b1;
  assign key_pos_next   = (key_pos_inc >= (KEY_AW + 1)'(key_len)) ? '0
                                                                  : key_pos_inc[KEY_AW-1:0];
  assign chunk_pos_next = (chunk_pos_inc >= (CHUNK_PW + 1)'(chunk_len)) ? '0
                                                                        : chunk_pos_inc[CHUNK_PW-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode  <= 1'b0;
      direction <= 1'b0;
      key_len   <= clamp_key_length(KEY_LENGTH_RESET);
      chunk_len <= clamp_chunk_length(CHUNK_LENGTH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_MODE:     key_mode  <= cfg_data[0];
        CFG_DIRECTION:    direction <= cfg_data[0];
        CFG_KEY_LENGTH:   key_len   <= clamp_key_length(cfg_data[8:0]);
        CFG_CHUNK_LENGTH: chunk_len <= clamp_chunk_length(cfg_data);
        default: ;
      endcase
    end
  end

  // Key store: write key bytes, read the current key position
  always_ff @(posedge clk) begin
    if (accept && is_key && key_wr_ok) begin
      key_store[KEY_AW'(item.key_index)] <= item.data_byte;
    end
    if (accept) begin
      key_rdata <= key_store[key_pos];
    end
  end

  // Read stage: advance positions
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos   <= '0;
      chunk_pos <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= is_data || is_restart;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (accept && is_restart) begin
        key_pos   <= '0;
        chunk_pos <= '0;
      end else if (accept && is_data) begin
        if (use_store) begin
          key_pos <= key_pos_next;
        end
        if (key_mode) begin
          chunk_pos <= chunk_pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= item.command;
      s1_reseed <= reseed;
      s1_data   <= item.data_byte;
      s1_last   <= item.last_in;
    end
  end

  // Key stage: LCG step, XOR and feedback
  assign seed_base = s1_reseed ? {24'd0, key_rdata} : lcg_seed;
  assign seed_next = seed_base * LCG_MUL + LCG_ADD;
  assign key_byte  = key_mode ? seed_next[23:16] : key_rdata;
  assign cipher    = s1_data ^ key_byte ^ feedback_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_seed      <= '0;
      feedback_byte <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (s1_fire) begin
        result_valid <= (s1_cmd == CMD_DATA);
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (s1_fire && s1_cmd == CMD_RESTART) begin
        lcg_seed      <= '0;
        feedback_byte <= '0;
      end else if (s1_fire && s1_cmd == CMD_DATA) begin
        if (key_mode) begin
          lcg_seed <= seed_next;
        end
        feedback_byte <= direction ? s1_data : cipher;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cmd == CMD_DATA) begin
      result.out_byte <= cipher;
      result.last_out <= s1_last;
    end
  end

  a_stall_needs_full_pipe: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("item_stall without both stages occupied");

  a_result_from_read_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result appeared without a transaction in the read stage");

  a_restart_clears_positions: assert property (@(posedge clk) disable iff (rst)
    (accept && is_restart) |=> (key_pos == '0 && chunk_pos == '0))
    else $error("restart did not clear key and chunk positions");

  a_reset_empties_pipe: assert property (@(posedge clk)
    rst |=> (!result_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_chunk_held_in_stored_mode: assert property (@(posedge clk) disable iff (rst)
    (accept && is_data && !key_mode) |=> $stable(chunk_pos))
    else $error("chunk position moved in stored key mode");

endmodule
